// ----- design/gai_pkg.sv -----
// ----------------------------------------------------------------------------
// gai_pkg
// Shared types and constants for the gyro angle integrator: microcode word,
// status flags, configuration bundle and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package gai_pkg;

  localparam int RATE_W  = 16;
  localparam int STAMP_W = 24;
  localparam int ANGLE_W = 31;
  localparam int CFG_W   = 15;
  localparam int CIDX_W  = 2;
  localparam int SUM_W   = 57;
  localparam int PC_W    = 5;
  localparam int AXIS_W  = 2;
  localparam int AXES    = 3;

  // register indexes on the configuration port
  localparam logic [CIDX_W-1:0] CFG_SCALE    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_DEADBAND = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_GAIN     = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_TICK     = 2'd3;

  localparam logic [9:0]  SCALE_RST    = 10'd610;
  localparam logic [14:0] DEADBAND_RST = 15'd20;
  localparam logic [3:0]  GAIN_RST     = 4'd2;
  localparam logic [7:0]  TICK_RST     = 8'd10;

  // x / 10 == (x * RECIP10) >> 35 for every 32-bit unsigned x
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic signed [SUM_W-1:0] FULL_TURN   = SUM_W'(360_000_000);
  localparam logic signed [SUM_W-1:0] ANGLE_CLAMP = SUM_W'(720_000_000);

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_START,
    OP_DT,
    OP_LD_DT,
    OP_GAIN,
    OP_NEG,
    OP_SCALE,
    OP_RECIP,
    OP_DELTA,
    OP_SUM,
    OP_WRAP_HI,
    OP_WRAP_LO,
    OP_SAT,
    OP_INT_DONE,
    OP_DEC_ABS,
    OP_DEC_MUL,
    OP_DEC_SUB,
    OP_STILL_DONE,
    OP_PRIME,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_PRIMED,
    C_RPT_STAMP,
    C_STILL,
    C_AXIS_MORE,
    C_OUT_BLOCKED
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
    logic  last;
  } ctrl_t;

  typedef struct packed {
    logic primed;
    logic rpt_stamp;
    logic still;
    logic axis_last;
  } status_t;

  typedef struct packed {
    logic [9:0]  scale_tenths;
    logic [14:0] deadband;
    logic [3:0]  speed_gain;
    logic [7:0]  tick_us;
  } cfg_t;

endpackage

// ----- design/gai_seq.sv -----
// ----------------------------------------------------------------------------
// gai_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module gai_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  gai_pkg::status_t status,
  input  logic             out_blocked,
  output gai_pkg::ctrl_t   ctrl,
  output logic             busy
);
  import gai_pkg::*;

  localparam pc_t A_START = 5'd0;
  localparam pc_t A_GAIN  = 5'd5;
  localparam pc_t A_DEC   = 5'd15;
  localparam pc_t A_PRIME = 5'd19;
  localparam pc_t A_EMIT  = 5'd20;

  localparam ctrl_t IDLE_WORD = '{op: OP_NOP, cond: C_NEVER, target: A_START, last: 1'b0};

  pc_t  pc_r;
  logic busy_r;
  logic take;

  function automatic ctrl_t rom(pc_t a);
    ctrl_t w;
    w = '{op: OP_NOP, cond: C_NEVER, target: A_EMIT, last: 1'b0};
    unique case (a)
      5'd0:  begin w.op = OP_START;      w.cond = C_NOT_PRIMED; w.target = A_PRIME; end
      5'd1:  begin w.op = OP_NOP;        w.cond = C_RPT_STAMP;  w.target = A_EMIT;  end
      5'd2:  begin w.op = OP_NOP;        w.cond = C_STILL;      w.target = A_DEC;   end
      5'd3:  w.op = OP_DT;
      5'd4:  w.op = OP_LD_DT;
      5'd5:  w.op = OP_GAIN;
      5'd6:  w.op = OP_NEG;
      5'd7:  w.op = OP_SCALE;
      5'd8:  w.op = OP_RECIP;
      5'd9:  w.op = OP_DELTA;
      5'd10: w.op = OP_SUM;
      5'd11: w.op = OP_WRAP_HI;
      5'd12: w.op = OP_WRAP_LO;
      5'd13: begin w.op = OP_SAT;        w.cond = C_AXIS_MORE;  w.target = A_GAIN;  end
      5'd14: begin w.op = OP_INT_DONE;   w.cond = C_ALWAYS;     w.target = A_EMIT;  end
      5'd15: w.op = OP_DEC_ABS;
      5'd16: w.op = OP_DEC_MUL;
      5'd17: begin w.op = OP_DEC_SUB;    w.cond = C_AXIS_MORE;  w.target = A_DEC;   end
      5'd18: begin w.op = OP_STILL_DONE; w.cond = C_ALWAYS;     w.target = A_EMIT;  end
      5'd19: begin w.op = OP_PRIME;      w.cond = C_ALWAYS;     w.target = A_EMIT;  end
      5'd20: begin
        w.op = OP_EMIT; w.cond = C_OUT_BLOCKED; w.target = A_EMIT; w.last = 1'b1;
      end
      default: begin w.op = OP_NOP; w.cond = C_ALWAYS; w.target = A_EMIT; end
    endcase
    return w;
  endfunction

  assign ctrl = busy_r ? rom(pc_r) : IDLE_WORD;
  assign busy = busy_r;

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NOT_PRIMED:  take = !status.primed;
      C_RPT_STAMP:   take = status.rpt_stamp;
      C_STILL:       take = status.still;
      C_AXIS_MORE:   take = !status.axis_last;
      C_OUT_BLOCKED: take = out_blocked;
      default:       take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= A_START;
    end else if (start) begin
      busy_r <= 1'b1;
      pc_r   <= A_START;
    end else if (busy_r) begin
      if (take) begin
        pc_r <= ctrl.target;
      end else if (ctrl.last) begin
        busy_r <= 1'b0;
      end else begin
        pc_r <= pc_r + 1'b1;
      end
    end
  end

endmodule

// ----- design/gai_datapath.sv -----
// ----------------------------------------------------------------------------
// gai_datapath
// Angle state, sample latch and the shared 32x32 multiplier, steered by the
// current microcode word.
// ----------------------------------------------------------------------------
module gai_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               ld,
  input  logic signed [gai_pkg::RATE_W-1:0]  rate_x,
  input  logic signed [gai_pkg::RATE_W-1:0]  rate_y,
  input  logic signed [gai_pkg::RATE_W-1:0]  rate_z,
  input  logic        [gai_pkg::STAMP_W-1:0] stamp,
  input  gai_pkg::cfg_t                      cfg,
  input  gai_pkg::ctrl_t                     ctrl,
  output gai_pkg::status_t                   status,
  output logic signed [gai_pkg::ANGLE_W-1:0] angle_x,
  output logic signed [gai_pkg::ANGLE_W-1:0] angle_y,
  output logic signed [gai_pkg::ANGLE_W-1:0] angle_z,
  output logic                               still,
  output logic                               fresh
);
  import gai_pkg::*;

  // sample latch
  logic signed [RATE_W-1:0]  rate_r [AXES];
  logic        [STAMP_W-1:0] stamp_r;

  // state
  logic signed [ANGLE_W-1:0] acc_r [AXES];
  logic        [STAMP_W-1:0] last_int_r;
  logic        [STAMP_W-1:0] last_seen_r;
  logic                      primed_r;
  logic        [AXIS_W-1:0]  axis_r;
  logic                      still_r;
  logic                      fresh_r;

  // working registers
  logic [63:0]               prod_r;
  logic [31:0]               dtus_r;
  logic [ANGLE_W-1:0]        mag_r;
  logic                      sign_r;
  logic signed [SUM_W-1:0]   sum_r;

  logic [31:0]               mul_a;
  logic [31:0]               mul_b;
  logic                      mul_en;
  logic [63:0]               mul_p;
  logic signed [RATE_W-1:0]  rate_sel;
  logic signed [ANGLE_W-1:0] acc_sel;
  logic [STAMP_W-1:0]        dt;
  logic [RATE_W-1:0]         g16;
  logic [RATE_W:0]           g_mag;
  logic [ANGLE_W-1:0]        acc_mag;
  logic [21:0]               q_rate;
  logic [26:0]               q_dec;
  logic [ANGLE_W-1:0]        q_dec_w;
  logic [SUM_W-1:0]          delta_mag;
  logic signed [SUM_W-1:0]   delta_s;
  logic signed [SUM_W-1:0]   acc_ext;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic signed [ANGLE_W-1:0] sat_val;

  function automatic logic in_band(logic signed [RATE_W-1:0] r, logic [14:0] db);
    logic signed [RATE_W:0] r17;
    logic signed [RATE_W:0] d17;
    r17 = {r[RATE_W-1], r};
    d17 = {2'b00, db};
    return (r17 > -d17) && (r17 < d17);
  endfunction

  always_comb begin
    unique case (axis_r)
      2'd0:    begin rate_sel = rate_r[0]; acc_sel = acc_r[0]; end
      2'd1:    begin rate_sel = rate_r[1]; acc_sel = acc_r[1]; end
      default: begin rate_sel = rate_r[2]; acc_sel = acc_r[2]; end
    endcase
  end

  assign dt      = stamp_r - last_int_r;
  assign g16     = RATE_W'(~prod_r[RATE_W-1:0] + 1'b1);
  // magnitude of the negated, wrapped rate; the most negative code maps to 2^15
  assign g_mag   = g16[RATE_W-1] ? (RATE_W+1)'(17'h1_0000 - {1'b0, g16}) : {1'b0, g16};
  assign acc_mag = acc_sel[ANGLE_W-1] ? ANGLE_W'(~acc_sel + 1'b1) : ANGLE_W'(acc_sel);
  assign q_rate  = prod_r[RECIP_SHIFT+21:RECIP_SHIFT];
  assign q_dec   = prod_r[RECIP_SHIFT+26:RECIP_SHIFT];
  assign q_dec_w = {4'b0000, q_dec};

  assign delta_mag = {3'b000, prod_r[53:0]};
  assign delta_s   = sign_r ? $signed(SUM_W'(~delta_mag + 1'b1)) : $signed(delta_mag);
  assign acc_ext   = {{(SUM_W-ANGLE_W){acc_sel[ANGLE_W-1]}}, acc_sel};
  assign sum_nxt   = acc_ext + delta_s;

  always_comb begin
    priority if (sum_r > ANGLE_CLAMP) sat_val = ANGLE_W'(ANGLE_CLAMP);
    else if (sum_r < -ANGLE_CLAMP)    sat_val = ANGLE_W'(-ANGLE_CLAMP);
    else                              sat_val = ANGLE_W'(sum_r);
  end

  // operand steering for the one shared multiplier
  always_comb begin
    mul_en = 1'b1;
    unique case (ctrl.op)
      OP_DT:      begin mul_a = {8'd0, dt};            mul_b = {24'd0, cfg.tick_us};      end
      OP_GAIN:    begin mul_a = {16'd0, rate_sel};     mul_b = {28'd0, cfg.speed_gain};   end
      OP_SCALE:   begin mul_a = {1'b0, mag_r};         mul_b = {22'd0, cfg.scale_tenths}; end
      OP_RECIP:   begin mul_a = prod_r[31:0];          mul_b = RECIP10;                   end
      OP_DELTA:   begin mul_a = {10'd0, q_rate};       mul_b = dtus_r;                    end
      OP_DEC_MUL: begin mul_a = {1'b0, mag_r};         mul_b = RECIP10;                   end
      default:    begin mul_a = 32'd0; mul_b = 32'd0; mul_en = 1'b0;                    end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (ld) begin
      rate_r[0] <= rate_x;
      rate_r[1] <= rate_y;
      rate_r[2] <= rate_z;
      stamp_r   <= stamp;
    end
    if (mul_en) begin
      prod_r <= mul_p;
    end
    unique case (ctrl.op)
      OP_LD_DT:   dtus_r <= prod_r[31:0];
      OP_NEG:     begin mag_r <= {{(ANGLE_W-RATE_W-1){1'b0}}, g_mag}; sign_r <= g16[RATE_W-1]; end
      OP_DEC_ABS: begin mag_r <= acc_mag; sign_r <= acc_sel[ANGLE_W-1]; end
      OP_SUM:     sum_r <= sum_nxt;
      OP_WRAP_HI: if (sum_r > FULL_TURN) sum_r <= sum_r - FULL_TURN;
      OP_WRAP_LO: if (sum_r < -FULL_TURN) sum_r <= sum_r + FULL_TURN;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r[0]    <= '0;
      acc_r[1]    <= '0;
      acc_r[2]    <= '0;
      last_int_r  <= '0;
      last_seen_r <= '0;
      primed_r    <= 1'b0;
      axis_r      <= '0;
      still_r     <= 1'b0;
      fresh_r     <= 1'b0;
    end else begin
      unique case (ctrl.op)
        OP_START: begin
          axis_r  <= '0;
          still_r <= 1'b0;
          fresh_r <= 1'b0;
        end
        OP_SAT: begin
          acc_r[axis_r] <= sat_val;
          axis_r        <= axis_r + 1'b1;
        end
        OP_DEC_SUB: begin
          acc_r[axis_r] <= sign_r ? acc_sel + $signed(q_dec_w) : acc_sel - $signed(q_dec_w);
          axis_r        <= axis_r + 1'b1;
        end
        OP_INT_DONE: begin
          last_int_r  <= stamp_r;
          last_seen_r <= stamp_r;
          fresh_r     <= 1'b1;
        end
        OP_STILL_DONE: begin
          last_seen_r <= stamp_r;
          still_r     <= 1'b1;
          fresh_r     <= 1'b1;
        end
        OP_PRIME: begin
          last_int_r <= stamp_r;
          primed_r   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign status.primed    = primed_r;
  assign status.rpt_stamp = (stamp_r == last_seen_r);
  assign status.still     = in_band(rate_r[0], cfg.deadband) && in_band(rate_r[1], cfg.deadband)
                            && in_band(rate_r[2], cfg.deadband);
  assign status.axis_last = (axis_r == AXIS_W'(AXES - 1));

  assign angle_x = acc_r[0];
  assign angle_y = acc_r[1];
  assign angle_z = acc_r[2];
  assign still   = still_r;
  assign fresh   = fresh_r;

endmodule

// ----- design/gyro_angle_integrator_core.sv -----
// ----------------------------------------------------------------------------
// gyro_angle_integrator_core
// Three-axis gyro rate integrator with deadband decay, microcode controlled.
// ----------------------------------------------------------------------------
// One sample at a time. Each transfer on the input channel yields exactly one
// result transfer carrying the three angles (1e-6 degree units) after that
// sample. A sample that only primes the timestamp, or repeats the previous
// one, does no integration; a still sample (all rates inside the deadband)
// runs the decay steps instead of the integration. Input stall drops in the
// cycle after the last step, and no new sample is taken before then. The
// integration work centres on the single shared 32x32 multiplier: every axis
// goes through it four times (gain, range factor, divide by ten, elapsed
// time), followed by the wrap and clamp steps, all sequenced by microcode.
// The result sits in an output register, so the block only waits on a
// stalled result when the next one is ready to go out.
// ----------------------------------------------------------------------------
module gyro_angle_integrator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // sample channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [gai_pkg::RATE_W-1:0]  in_rate_x,
  input  logic signed [gai_pkg::RATE_W-1:0]  in_rate_y,
  input  logic signed [gai_pkg::RATE_W-1:0]  in_rate_z,
  input  logic        [gai_pkg::STAMP_W-1:0] in_stamp,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [gai_pkg::ANGLE_W-1:0] out_angle_x,
  output logic signed [gai_pkg::ANGLE_W-1:0] out_angle_y,
  output logic signed [gai_pkg::ANGLE_W-1:0] out_angle_z,
  output logic                               out_still,
  output logic                               out_fresh,
  // configuration writes
  input  logic                               cfg_wr_en,
  input  logic        [gai_pkg::CIDX_W-1:0]  cfg_index,
  input  logic        [gai_pkg::CFG_W-1:0]   cfg_wdata
);
  import gai_pkg::*;

  cfg_t    cfg_r;
  ctrl_t   ctrl;
  status_t status;
  logic    busy;
  logic    in_xfer;
  logic    out_blocked;
  logic    emit;

  logic signed [ANGLE_W-1:0] dp_ax;
  logic signed [ANGLE_W-1:0] dp_ay;
  logic signed [ANGLE_W-1:0] dp_az;
  logic                      dp_still;
  logic                      dp_fresh;

  logic                      out_valid_r;
  logic signed [ANGLE_W-1:0] out_ax_r;
  logic signed [ANGLE_W-1:0] out_ay_r;
  logic signed [ANGLE_W-1:0] out_az_r;
  logic                      out_still_r;
  logic                      out_fresh_r;

  // stall while the sequencer owns the sample latch
  assign in_stall    = busy;
  assign in_xfer     = in_valid && !in_stall;
  assign out_blocked = out_valid_r && out_stall;
  // the emit step holds in place until the output register can take the result
  assign emit        = (ctrl.op == OP_EMIT) && !out_blocked;

  // configuration registers; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_tenths <= SCALE_RST;
      cfg_r.deadband     <= DEADBAND_RST;
      cfg_r.speed_gain   <= GAIN_RST;
      cfg_r.tick_us      <= TICK_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SCALE:    cfg_r.scale_tenths <= cfg_wdata[9:0];
        CFG_DEADBAND: cfg_r.deadband     <= cfg_wdata[14:0];
        CFG_GAIN:     cfg_r.speed_gain   <= cfg_wdata[3:0];
        CFG_TICK:     cfg_r.tick_us      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  gai_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_xfer),
    .status      (status),
    .out_blocked (out_blocked),
    .ctrl        (ctrl),
    .busy        (busy)
  );

  gai_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ld      (in_xfer),
    .rate_x  (in_rate_x),
    .rate_y  (in_rate_y),
    .rate_z  (in_rate_z),
    .stamp   (in_stamp),
    .cfg     (cfg_r),
    .ctrl    (ctrl),
    .status  (status),
    .angle_x (dp_ax),
    .angle_y (dp_ay),
    .angle_z (dp_az),
    .still   (dp_still),
    .fresh   (dp_fresh)
  );

  // output register: a new result may replace one leaving in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ax_r    <= dp_ax;
      out_ay_r    <= dp_ay;
      out_az_r    <= dp_az;
      out_still_r <= dp_still;
      out_fresh_r <= dp_fresh;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_angle_x = out_ax_r;
  assign out_angle_y = out_ay_r;
  assign out_angle_z = out_az_r;
  assign out_still   = out_still_r;
  assign out_fresh   = out_fresh_r;

  // a taken sample always keeps the input stalled on the next cycle
  a_xfer_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("sample taken but sequencer not busy");

  // a result only appears after the emit step of a running program
  a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(emit))
    else $error("result raised without emit step");

  // emit only happens while a sample is being worked on
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> busy)
    else $error("emit outside a program run");

  // a decayed sample is always a processed one
  a_still_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_still |-> out_fresh)
    else $error("still result without fresh flag");

endmodule
